// File: src/rbd_pkg.sv
// Package for the ring buffer deque: command and status codes, the datapath
// address selector, and the command/status structs between controller and datapath.
// No dependencies.
package rbd_pkg;

   // Command codes carried in the low bits of the request beat. Codes 6 and 7 are unused.
   typedef enum logic [2:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_READ       = 3'd4,
      CMD_WRITE      = 3'd5
   } cmd_type;

   // Status codes returned with every response beat.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } stat_type;

   // Which physical slot the store is accessed at.
   typedef enum logic [2:0] {
      ADDR_TAIL,
      ADDR_LAST,
      ADDR_POS,
      ADDR_HEAD,
      ADDR_HEAD_DEC
   } addr_sel_type;

   localparam int unsigned REQ_DATA_BITS = 72;
   localparam int unsigned RSP_DATA_BITS = 72;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_req;
      logic         access;
      addr_sel_type addr_sel;
      logic         mem_we;
      logic         head_inc;
      logic         head_dec;
      logic         cnt_inc;
      logic         cnt_dec;
      stat_type     status;
      logic         rd_ok;
      logic         load_rsp;
   } dp_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    pos_ok;
   } dp_stat_type;

endpackage

// File: src/rbd_datapath.sv
// Datapath of the ring buffer deque: captured request, head pointer, element
// count, the circular store and the response register. Uses rbd_pkg.
module rbd_datapath
   import rbd_pkg::*;
#(
   parameter int unsigned CAPACITY     = 16,
   parameter int unsigned ELEMENT_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [REQ_DATA_BITS-1:0] req_data,
   input  dp_ctrl_type              ctrl,
   output dp_stat_type              stat,
   output logic [RSP_DATA_BITS-1:0] rsp_data
);

   localparam int unsigned PTR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned SUM_W = PTR_W + 1;
   localparam int unsigned IDX_W = (CNT_W > 4) ? CNT_W : 4;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
   localparam logic [SUM_W-1:0] CAP_SUM   = SUM_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);

   cmd_type                 cmd_ff;
   logic [ELEMENT_BITS-1:0] value_ff;
   logic [3:0]              pos_ff;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   stat_type                status_ff;
   logic                    rd_ok_ff;
   logic [63:0]             rsp_value_ff;
   stat_type                rsp_status_ff;
   logic [4:0]              rsp_occ_ff;

   logic [ELEMENT_BITS-1:0] store [CAPACITY];
   logic [ELEMENT_BITS-1:0] rd_q;

   logic [PTR_W-1:0] head_prev, head_next, addr;
   logic [SUM_W-1:0] logical, slot_sum, slot_wrap;

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         cmd_ff   <= cmd_type'(req_data[2:0]);
         value_ff <= req_data[3 +: ELEMENT_BITS];
         pos_ff   <= req_data[70:67];
      end
   end

   assign stat.cmd    = cmd_ff;
   assign stat.full   = (count_ff == CAP_CNT);
   assign stat.empty  = (count_ff == '0);
   assign stat.pos_ok = (IDX_W'(pos_ff) < IDX_W'(count_ff));

   assign head_prev = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;

   // Slot of a logical index: head plus index, folded once, since the sum
   // stays below twice the capacity.
   always_comb begin
      case (ctrl.addr_sel)
         ADDR_LAST: logical = SUM_W'(count_ff) - 1'b1;
         ADDR_POS:  logical = SUM_W'(pos_ff);
         default:   logical = SUM_W'(count_ff);
      endcase
      slot_sum  = SUM_W'(head_ff) + logical;
      slot_wrap = (slot_sum >= CAP_SUM) ? slot_sum - CAP_SUM : slot_sum;
      case (ctrl.addr_sel)
         ADDR_HEAD:     addr = head_ff;
         ADDR_HEAD_DEC: addr = head_prev;
         default:       addr = slot_wrap[PTR_W-1:0];
      endcase
   end

   // The read data is held until the response register takes it, which may
   // be delayed while the previous response is still waiting.
   always_ff @(posedge clock) begin
      if (ctrl.access) begin
         if (ctrl.mem_we) begin
            store[addr] <= value_ff;
         end
         rd_q <= store[addr];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.access) begin
         if (ctrl.head_inc) begin
            head_in = head_next;
         end else if (ctrl.head_dec) begin
            head_in = head_prev;
         end
         if (ctrl.cnt_inc) begin
            count_in = count_ff + 1'b1;
         end else if (ctrl.cnt_dec) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.access) begin
         status_ff <= ctrl.status;
         rd_ok_ff  <= ctrl.rd_ok;
      end
      if (ctrl.load_rsp) begin
         rsp_value_ff  <= rd_ok_ff ? 64'(rd_q) : 64'd0;
         rsp_status_ff <= status_ff;
         rsp_occ_ff    <= 5'(count_ff);
      end
   end

   assign rsp_data = {1'b0, rsp_occ_ff, rsp_status_ff, rsp_value_ff};

endmodule

// File: src/rbd_control.sv
// Controller of the ring buffer deque: request/response handshakes and the
// per-command decision. Uses rbd_pkg.
module rbd_control
   import rbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  dp_stat_type stat,
   output dp_ctrl_type ctrl
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_ACCESS = 3'b010,
      S_RESULT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      ctrl.addr_sel = ADDR_TAIL;
      ctrl.status   = STAT_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctrl.load_req = 1'b1;
               state_in      = S_ACCESS;
            end
         end
         S_ACCESS: begin
            ctrl.access = 1'b1;
            state_in    = S_RESULT;
            unique case (stat.cmd)
               CMD_PUSH_BACK: begin
                  if (stat.full) begin
                     ctrl.status = STAT_FULL;
                  end else begin
                     ctrl.addr_sel = ADDR_TAIL;
                     ctrl.mem_we   = 1'b1;
                     ctrl.cnt_inc  = 1'b1;
                  end
               end
               CMD_PUSH_FRONT: begin
                  if (stat.full) begin
                     ctrl.status = STAT_FULL;
                  end else begin
                     ctrl.addr_sel = ADDR_HEAD_DEC;
                     ctrl.mem_we   = 1'b1;
                     ctrl.head_dec = 1'b1;
                     ctrl.cnt_inc  = 1'b1;
                  end
               end
               CMD_POP_BACK: begin
                  if (stat.empty) begin
                     ctrl.status = STAT_EMPTY;
                  end else begin
                     ctrl.addr_sel = ADDR_LAST;
                     ctrl.rd_ok    = 1'b1;
                     ctrl.cnt_dec  = 1'b1;
                  end
               end
               CMD_POP_FRONT: begin
                  if (stat.empty) begin
                     ctrl.status = STAT_EMPTY;
                  end else begin
                     ctrl.addr_sel = ADDR_HEAD;
                     ctrl.rd_ok    = 1'b1;
                     ctrl.head_inc = 1'b1;
                     ctrl.cnt_dec  = 1'b1;
                  end
               end
               CMD_READ: begin
                  if (stat.pos_ok) begin
                     ctrl.addr_sel = ADDR_POS;
                     ctrl.rd_ok    = 1'b1;
                  end else begin
                     ctrl.status = STAT_RANGE;
                  end
               end
               CMD_WRITE: begin
                  if (stat.pos_ok) begin
                     ctrl.addr_sel = ADDR_POS;
                     ctrl.mem_we   = 1'b1;
                  end else begin
                     ctrl.status = STAT_RANGE;
                  end
               end
               default: begin
                  // Unused codes leave the state alone and answer OK with zero data.
                  ctrl.status = STAT_OK;
               end
            endcase
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctrl.load_rsp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/ring_buffer_deque.sv
// Top level of the ring buffer deque: controller plus datapath.
// Depends on rbd_pkg, rbd_control and rbd_datapath.
//
// Usage: each request beat carries one command (push back, push front, pop
// back, pop front, read at a logical index, write at a logical index). Every
// request produces exactly one response beat with the popped or read element
// (zero when nothing is returned or the command fails), a status code and the
// element count after the command.
// Sequence: the idle state captures an accepted request, the access state
// addresses the store, and the result state moves the read data into the
// response register once that register is free; the store's registered read
// port sets this order. A new request is accepted only back in the idle state.
// Stalls: the response register holds a finished beat while rsp_tready is low,
// and the block still accepts and works on the next request; it waits only
// before loading a second response over one that was not taken.
// Reset: synchronous and active high; the deque comes out empty with the head
// at slot zero. The store is not cleared, since only live entries are read.
module ring_buffer_deque
   import rbd_pkg::*;
#(
   parameter int unsigned CAPACITY     = 16,
   parameter int unsigned ELEMENT_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // Fields from bit 0 up: cmd[2:0], element_value[66:3], position[70:67], zero[71].
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // Fields from bit 0 up: read_value[63:0], status[65:64], occupancy[70:66], zero[71].
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   rbd_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   rbd_datapath #(
      .CAPACITY     (CAPACITY),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_tdata),
      .ctrl     (ctrl),
      .stat     (stat),
      .rsp_data (rsp_tdata)
   );

   // A request moves the controller out of idle, so no second beat is taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a command is in flight");

   // A failed command never returns data.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65:64] != STAT_OK) |-> (rsp_tdata[63:0] == 64'd0))
      else $error("failed command returned nonzero data");

   // An empty rejection reports a count of zero.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65:64] == STAT_EMPTY) |-> (rsp_tdata[70:66] == 5'd0))
      else $error("empty status with nonzero occupancy");

   // A full rejection reports the capacity as the count.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65:64] == STAT_FULL) |-> (rsp_tdata[70:66] == 5'(CAPACITY)))
      else $error("full status with occupancy below capacity");

   // The datapath never reports the deque as both full and empty.
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      !(stat.full && stat.empty))
      else $error("deque flagged full and empty at once");

endmodule

// File: bench/ring_buffer_deque_test.sv
`timescale 1ns / 1ps
// Self-checking bench for ring_buffer_deque: drives command beats, predicts every response
// from a shadow copy of the deque and compares the response beats field by field.
// Depends on rbd_pkg and the ring_buffer_deque RTL.
module ring_buffer_deque_test;
   import rbd_pkg::*;

   localparam int unsigned DEPTH      = 16;
   localparam int unsigned ELEM_BITS  = 64;
   localparam int unsigned CYCLE_CAP  = 300000;
   // Codes 6 and 7 are not commands; the block answers them with the count unchanged.
   localparam logic [2:0]  CMD_SPARE_6 = 3'd6;
   localparam logic [2:0]  CMD_SPARE_7 = 3'd7;
   localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [63:0] read_value;
      stat_type    status;
      logic [4:0]  occupancy;
   } deque_result_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   // Fields from bit 0 up: cmd[2:0], element_value[66:3], position[70:67], zero[71].
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   // Fields from bit 0 up: read_value[63:0], status[65:64], occupancy[70:66], zero[71].
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   // Shadow state of the deque, updated when a request beat is accepted.
   logic [63:0] shadow_store [DEPTH];
   logic [3:0]  shadow_head;
   logic [4:0]  shadow_count;

   deque_result_type pending_results[$];
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          send_idle_pct  = 0;
   int          recv_idle_pct  = 0;
   int          hold_request   = 0;
   bit          filling        = 1'b1;

   ring_buffer_deque #(
      .CAPACITY     (DEPTH),
      .ELEMENT_BITS (ELEM_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Runaway guard: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Applies one command to the shadow deque and returns the response it should produce.
   function automatic deque_result_type predict_command(logic [2:0] cmd, logic [63:0] value,
                                                        logic [3:0] pos);
      deque_result_type res;
      res.read_value = '0;
      res.status     = STAT_OK;
      case (cmd)
         CMD_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               shadow_store[4'(shadow_head + shadow_count[3:0])] = value;
               shadow_count++;
            end
         end
         CMD_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               shadow_head = shadow_head - 4'd1;
               shadow_store[shadow_head] = value;
               shadow_count++;
            end
         end
         CMD_POP_BACK: begin
            if (shadow_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.read_value = shadow_store[4'(shadow_head + shadow_count[3:0] - 4'd1)];
               shadow_count--;
            end
         end
         CMD_POP_FRONT: begin
            if (shadow_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.read_value = shadow_store[shadow_head];
               shadow_head = shadow_head + 4'd1;
               shadow_count--;
            end
         end
         CMD_READ: begin
            if ({1'b0, pos} >= shadow_count) begin
               res.status = STAT_RANGE;
            end else begin
               res.read_value = shadow_store[4'(shadow_head + pos)];
            end
         end
         CMD_WRITE: begin
            if ({1'b0, pos} >= shadow_count) begin
               res.status = STAT_RANGE;
            end else begin
               shadow_store[4'(shadow_head + pos)] = value;
            end
         end
         default: begin
            // Spare codes leave the deque alone.
         end
      endcase
      res.occupancy = shadow_count;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH at %0t: %s got %h, want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Sends one request beat. Called at a falling edge and returns at a falling edge with
   // valid still high, so back-to-back beats never lower and raise valid in one step.
   task automatic send_command(logic [2:0] cmd, logic [63:0] value, logic [3:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, pos, value, cmd};
      do begin
         @(posedge clock);
      end while (!req_tready);
      pending_results.push_back(predict_command(cmd, value, pos));
      @(negedge clock);
   endtask

   function automatic logic [63:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 10) return ALL_ONES;
      if (r < 15) return '0;
      return {$urandom, $urandom};
   endfunction

   // Errors on an empty deque and the spare codes; the next task fills the deque so the
   // head pointer wraps and it ends full, with pushes at both ends bouncing off.
   task automatic test_empty_errors();
      send_command(CMD_POP_BACK, ALL_ONES, 4'd0);
      send_command(CMD_POP_FRONT, ALL_ONES, 4'd15);
      send_command(CMD_READ, '0, 4'd15);
      send_command(CMD_WRITE, ALL_ONES, 4'd0);
      send_command(CMD_SPARE_6, ALL_ONES, 4'd15);
      send_command(CMD_SPARE_7, 64'h5A5A_5A5A_A5A5_A5A5, 4'd0);
   endtask

   task automatic test_full_wrap();
      for (int i = 0; i < DEPTH; i++) begin
         // Push front first so the head wraps below slot zero right away.
         if (i % 2 == 0)
            send_command(CMD_PUSH_FRONT, (i % 4 == 0) ? ALL_ONES : 64'h0, 4'(i));
         else
            send_command(CMD_PUSH_BACK, {$urandom, $urandom}, 4'(i));
      end
      send_command(CMD_PUSH_BACK, ALL_ONES, 4'd0);
      send_command(CMD_PUSH_FRONT, '0, 4'd15);
      send_command(CMD_WRITE, 64'hAAAA_AAAA_5555_5555, 4'd15);
      send_command(CMD_READ, '0, 4'd15);
   endtask

   // Random traffic that sweeps the count between empty and full, so pops, pushes, reads
   // and writes land on every occupancy and every head position. Spare codes are sprinkled
   // in as noise and do not count toward the item total.
   task automatic test_random_traffic(int n_items);
      int         sent;
      int         r;
      logic [2:0] cmd;
      logic [3:0] pos;
      sent = 0;
      while (sent < n_items) begin
         if (shadow_count == DEPTH) filling = 1'b0;
         if (shadow_count == 0) filling = 1'b1;
         if ($urandom_range(99) < 4) filling = ~filling;
         r = $urandom_range(99);
         if (r < 3) begin
            cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
         end else if (r < 55) begin
            if (filling) cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
         end else if (r < 70) begin
            if (filling) cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
            else cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         end else begin
            cmd = $urandom_range(1) ? CMD_READ : CMD_WRITE;
         end
         if (shadow_count != 0 && $urandom_range(99) < 80)
            pos = 4'($urandom_range(shadow_count - 1));
         else
            pos = 4'($urandom_range(15));
         send_command(cmd, pick_value(), pos);
         if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) sent++;
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering beats,
   // so the response register fills and the block stalls its request side.
   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_request  = 80;
      test_random_traffic(30);
   endtask

   // Response side: random ready, with a long hold-off counted down here when asked for.
   always @(negedge clock) begin : drive_ready
      static int hold_left = 0;
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response checker: every accepted beat is matched against the oldest prediction.
   always @(posedge clock) begin : check_response
      deque_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response beat with nothing pending", rsp_tdata[63:0], '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[63:0] !== want.read_value)
               report_mismatch("read_value", rsp_tdata[63:0], want.read_value);
            if (rsp_tdata[65:64] !== want.status)
               report_mismatch("status", 64'(rsp_tdata[65:64]), 64'(want.status));
            if (rsp_tdata[70:66] !== want.occupancy)
               report_mismatch("occupancy", 64'(rsp_tdata[70:66]), 64'(want.occupancy));
            if (rsp_tdata[71] !== 1'b0)
               report_mismatch("pad bit", 64'(rsp_tdata[71]), '0);
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      shadow_head  = '0;
      shadow_count = '0;
      for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 17;
      recv_idle_pct = 45;
      test_empty_errors();
      test_full_wrap();
      test_random_traffic(400);

      send_idle_pct = 45;
      recv_idle_pct = 17;
      test_random_traffic(400);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(400);

      test_backpressure();
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
